[design/rbb_pkg.sv]
// ----------------------------------------------------------------------------
// rbb_pkg: shared definitions for the rgb565 3x3 box blur
// widths, register indexes, result and pipeline structs, divide-by-nine helper
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int PIX_W      = 16;
    localparam int COL_W      = 9;
    localparam int ROW_W      = 8;
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 256;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int MIN_SIZE   = 3;

    localparam int FW_W       = 10;
    localparam int FH_W       = 9;
    localparam int CFG_DATA_W = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

    localparam logic [FW_W-1:0] FW_RESET = 10'd400;
    localparam logic [FH_W-1:0] FH_RESET = 9'd240;

    // output queue
    localparam int Q_DEPTH = 8;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    // results per input item
    localparam int N_SLOTS = 3;
    localparam int N_W     = 2;

    // field sums over nine pixels
    localparam int SUM5_W = 9;
    localparam int SUM6_W = 10;

    // floor(s / 9) == (s * 911) >> 13 for every s below 1168
    localparam int DIV9_MUL  = 911;
    localparam int DIV9_SH   = 13;
    localparam int DIV9_PR_W = 20;

    typedef logic [PIX_W-1:0] t_pixel;

    typedef struct packed {
        t_pixel             pixel;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               last;
    } t_result;

    typedef struct packed {
        t_pixel             pixel;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic               row0;
        logic               row_ge2;
        logic               col_ge1;
        logic               col1;
        logic               col_last;
        logic               row_last;
    } t_pos;

    typedef struct packed {
        logic [N_W-1:0]             n;
        t_result [N_SLOTS-1:0]      ent;
        logic                       mean;
        logic [SUM5_W-1:0]          sum_lo;
        logic [SUM6_W-1:0]          sum_mid;
        logic [SUM5_W-1:0]          sum_hi;
    } t_s1;

    typedef struct packed {
        logic                       push;
        logic [N_W-1:0]             n;
        t_result [N_SLOTS-1:0]      ent;
    } t_push;

    typedef struct packed {
        logic [Q_CNT_W-1:0] count;
    } t_q_stat;

    function automatic logic [5:0] div9(input logic [SUM6_W-1:0] s);
        logic [DIV9_PR_W-1:0] prod;
        prod = DIV9_PR_W'(s) * DIV9_PR_W'(DIV9_MUL);
        return prod[DIV9_SH +: 6];
    endfunction

endpackage

[design/rbb_in_if.sv]
// ----------------------------------------------------------------------------
// rbb_in_if: pixel input channel
// valid/ready handshake carrying one rgb565 pixel and a frame start flag
// ----------------------------------------------------------------------------
interface rbb_in_if import rbb_pkg::*; ();
    logic   valid;
    logic   ready;
    t_pixel in_pixel;
    logic   frame_start;

    modport source (output valid, output in_pixel, output frame_start, input ready);
    modport sink   (input valid, input in_pixel, input frame_start, output ready);
endinterface

[design/rbb_out_if.sv]
// ----------------------------------------------------------------------------
// rbb_out_if: result output channel
// valid/ready handshake carrying one pixel with its coordinates and last flag
// ----------------------------------------------------------------------------
interface rbb_out_if import rbb_pkg::*; ();
    logic             valid;
    logic             ready;
    t_pixel           out_pixel;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             last;

    modport source (output valid, output out_pixel, output out_col, output out_row,
                    output last, input ready);
    modport sink   (input valid, input out_pixel, input out_col, input out_row,
                    input last, output ready);
endinterface

[design/rgb565_box_blur_3x3.sv]
// path: a pixel is registered in the front stage, then the divide stage, then the queue
// throughput: one pixel per cycle while the divide stage and queue have room
// the last row gives two results per pixel past column 0, three at its last column
// the extra result at the end of each blurred row is taken up by the eight-entry output queue
// reset: counters, window, pipeline and queue clear; width 400, height 240; line stores kept
// ----------------------------------------------------------------------------
// rgb565_box_blur_3x3: streaming 3x3 box blur for rgb565 pixels
// tracks the raster position, feeds the line store stage, divides and queues
// ----------------------------------------------------------------------------
module rgb565_box_blur_3x3 import rbb_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rbb_in_if.sink                i_pix,
    rbb_out_if.source             o_res
);

    logic [FW_W-1:0]  r_frame_width;
    logic [FH_W-1:0]  r_frame_height;
    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;

    logic [FW_W-1:0]  w_eff;
    logic [FH_W-1:0]  h_eff;
    logic             in_ready;
    logic             accept;
    t_pos             pos;
    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic             s1_valid;
    t_s1              s1;
    logic             s2_ready;
    t_q_stat          q_stat;
    t_push            push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= FW_RESET;
            r_frame_height <= FH_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data;
                end
                REG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[FH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_frame_width < FW_W'(MIN_SIZE)) begin
            w_eff = FW_W'(MIN_SIZE);
        end else if (r_frame_width > FW_W'(MAX_WIDTH)) begin
            w_eff = FW_W'(MAX_WIDTH);
        end else begin
            w_eff = r_frame_width;
        end
        if (r_frame_height < FH_W'(MIN_SIZE)) begin
            h_eff = FH_W'(MIN_SIZE);
        end else if (r_frame_height > FH_W'(MAX_HEIGHT)) begin
            h_eff = FH_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_frame_height;
        end
    end

    // position of this transaction, and of the next one
    always_comb begin
        logic [ROW_W:0]   y_tmp;
        logic [ROW_W:0]   y_inc;
        logic [COL_W:0]   x_inc;

        if (i_pix.frame_start) begin
            pos.col = '0;
            y_tmp   = '0;
        end else if ({1'b0, r_col} >= w_eff) begin
            pos.col = '0;
            y_tmp   = {1'b0, r_row} + 1'b1;
        end else begin
            pos.col = r_col;
            y_tmp   = {1'b0, r_row};
        end
        pos.row      = (y_tmp >= h_eff) ? '0 : y_tmp[ROW_W-1:0];
        pos.pixel    = i_pix.in_pixel;
        pos.row0     = (pos.row == '0);
        pos.row_ge2  = (pos.row >= ROW_W'(2));
        pos.col_ge1  = (pos.col != '0);
        pos.col1     = (pos.col == COL_W'(1));
        pos.col_last = ({1'b0, pos.col} == (w_eff - 1'b1));
        pos.row_last = ({1'b0, pos.row} == (h_eff - 1'b1));

        x_inc = {1'b0, pos.col} + 1'b1;
        y_inc = {1'b0, pos.row} + 1'b1;
        if (x_inc >= w_eff) begin
            n_col = '0;
            n_row = (y_inc >= h_eff) ? '0 : y_inc[ROW_W-1:0];
        end else begin
            n_col = x_inc[COL_W-1:0];
            n_row = pos.row;
        end
    end

    assign accept      = i_pix.valid && in_ready;
    assign i_pix.ready = in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    rbb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_pos      (pos),
        .o_in_ready (in_ready),
        .o_s1_valid (s1_valid),
        .o_s1       (s1),
        .i_s2_ready (s2_ready)
    );

    rbb_mean u_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1       (s1),
        .o_s2_ready (s2_ready),
        .i_q_stat   (q_stat),
        .o_push     (push)
    );

    rbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_stat  (q_stat),
        .o_res   (o_res)
    );

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= Q_CNT_W'(Q_DEPTH))
        else $error("output queue over its depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.push |-> ((Q_CNT_W + 1)'(q_stat.count) + (Q_CNT_W + 1)'(push.n)
                       <= (Q_CNT_W + 1)'(Q_DEPTH)))
        else $error("results pushed without room in the queue");

    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_pix.frame_start |=> (r_col == COL_W'(1)) && (r_row == '0))
        else $error("frame start did not restart the position");

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_cfg_we |=> ({1'b0, r_col} < w_eff))
        else $error("column counter past the frame width");

endmodule

[design/rbb_ram.sv]
// ----------------------------------------------------------------------------
// rbb_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module rbb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/rbb_front.sv]
// ----------------------------------------------------------------------------
// rbb_front: line stores, window and result selection
// reads both line stores, sums the 3x3 fields and lists the results per pixel
// ----------------------------------------------------------------------------
module rbb_front import rbb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_accept,
    input  t_pos i_pos,
    output logic o_in_ready,
    output logic o_s1_valid,
    output t_s1  o_s1,
    input  logic i_s2_ready
);

    logic   r_s1v;
    t_pos   r_s1_pos;
    logic   r_fwd;
    t_pixel r_fwd_top;
    t_pixel r_fwd_mid;
    t_pixel r_win [6];

    logic   s1_adv;
    t_pixel older_rd;
    t_pixel newer_rd;
    t_pixel top;
    t_pixel mid;

    assign s1_adv     = r_s1v && i_s2_ready;
    assign o_in_ready = !r_s1v || s1_adv;
    assign o_s1_valid = r_s1v;

    rbb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_older (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_pos.col),
        .i_wdata (mid),
        .i_re    (i_accept),
        .i_raddr (i_pos.col),
        .o_rdata (older_rd)
    );

    rbb_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_newer (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_s1_pos.col),
        .i_wdata (r_s1_pos.pixel),
        .i_re    (i_accept),
        .i_raddr (i_pos.col),
        .o_rdata (newer_rd)
    );

    // same column read while the previous transaction writes it back
    assign top = r_fwd ? r_fwd_top : older_rd;
    assign mid = r_fwd ? r_fwd_mid : newer_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_fwd <= 1'b0;
        end else begin
            if (i_accept) begin
                r_s1v <= 1'b1;
                r_fwd <= s1_adv && (i_pos.col == r_s1_pos.col);
            end else if (s1_adv) begin
                r_s1v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1_pos  <= i_pos;
            r_fwd_top <= mid;
            r_fwd_mid <= r_s1_pos.pixel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (s1_adv) begin
            r_win[3] <= r_win[0];
            r_win[4] <= r_win[1];
            r_win[5] <= r_win[2];
            r_win[0] <= top;
            r_win[1] <= mid;
            r_win[2] <= r_s1_pos.pixel;
        end
    end

    always_comb begin
        t_pixel           nb [9];
        t_result          cand [4];
        logic             cv [4];
        logic [N_W-1:0]   k;
        logic             blur_slot;

        nb[0] = r_win[3];
        nb[1] = r_win[4];
        nb[2] = r_win[5];
        nb[3] = r_win[0];
        nb[4] = r_win[1];
        nb[5] = r_win[2];
        nb[6] = top;
        nb[7] = mid;
        nb[8] = r_s1_pos.pixel;

        o_s1.sum_lo  = '0;
        o_s1.sum_mid = '0;
        o_s1.sum_hi  = '0;
        for (int i = 0; i < 9; i++) begin
            o_s1.sum_lo  = o_s1.sum_lo  + SUM5_W'(nb[i][4:0]);
            o_s1.sum_mid = o_s1.sum_mid + SUM6_W'(nb[i][10:5]);
            o_s1.sum_hi  = o_s1.sum_hi  + SUM5_W'(nb[i][15:11]);
        end

        blur_slot = r_s1_pos.row_ge2 && r_s1_pos.col_ge1;

        // first row copy
        cv[0]         = r_s1_pos.row0;
        cand[0].pixel = r_s1_pos.pixel;
        cand[0].col   = r_s1_pos.col;
        cand[0].row   = '0;
        cand[0].last  = 1'b0;
        // pixel above-left: copy at column 0, mean elsewhere
        cv[1]         = blur_slot;
        cand[1].pixel = r_win[1];
        cand[1].col   = r_s1_pos.col - 1'b1;
        cand[1].row   = r_s1_pos.row - 1'b1;
        cand[1].last  = 1'b0;
        // last column of the row above
        cv[2]         = blur_slot && r_s1_pos.col_last;
        cand[2].pixel = mid;
        cand[2].col   = r_s1_pos.col;
        cand[2].row   = r_s1_pos.row - 1'b1;
        cand[2].last  = 1'b0;
        // last row copy
        cv[3]         = r_s1_pos.row_last;
        cand[3].pixel = r_s1_pos.pixel;
        cand[3].col   = r_s1_pos.col;
        cand[3].row   = r_s1_pos.row;
        cand[3].last  = 1'b0;

        o_s1.ent = '0;
        k = '0;
        for (int i = 0; i < 4; i++) begin
            if (cv[i] && (k != N_W'(N_SLOTS))) begin
                o_s1.ent[k] = cand[i];
                k = k + 1'b1;
            end
        end
        if (k != '0) begin
            o_s1.ent[k - 1'b1].last = 1'b1;
        end
        o_s1.n    = k;
        o_s1.mean = blur_slot && !r_s1_pos.col1;
    end

endmodule

[design/rbb_mean.sv]
// ----------------------------------------------------------------------------
// rbb_mean: divide stage
// divides the field sums by nine, repacks and hands results to the queue
// ----------------------------------------------------------------------------
module rbb_mean import rbb_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s1_valid,
    input  t_s1     i_s1,
    output logic    o_s2_ready,
    input  t_q_stat i_q_stat,
    output t_push   o_push
);

    logic r_s2v;
    t_s1  r_s2;

    logic [Q_CNT_W-1:0] free;
    logic               s2_adv;
    logic [5:0]         q_lo;
    logic [5:0]         q_mid;
    logic [5:0]         q_hi;

    assign free       = Q_CNT_W'(Q_DEPTH) - i_q_stat.count;
    assign s2_adv     = r_s2v && (free >= Q_CNT_W'(r_s2.n));
    assign o_s2_ready = !r_s2v || s2_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2v <= 1'b0;
        end else begin
            if (i_s1_valid && o_s2_ready) begin
                r_s2v <= 1'b1;
            end else if (s2_adv) begin
                r_s2v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s1_valid && o_s2_ready) begin
            r_s2 <= i_s1;
        end
    end

    assign q_lo  = div9(SUM6_W'(r_s2.sum_lo));
    assign q_mid = div9(r_s2.sum_mid);
    assign q_hi  = div9(SUM6_W'(r_s2.sum_hi));

    always_comb begin
        o_push.push = s2_adv;
        o_push.n    = r_s2.n;
        o_push.ent  = r_s2.ent;
        // the blurred pixel is always the first result of its transaction
        if (r_s2.mean) begin
            o_push.ent[0].pixel = {q_hi[4:0], q_mid, q_lo[4:0]};
        end
    end

endmodule

[design/rbb_queue.sv]
// ----------------------------------------------------------------------------
// rbb_queue: output queue
// takes up to three results a cycle, delivers one per output transaction
// ----------------------------------------------------------------------------
module rbb_queue import rbb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_push     i_push,
    output t_q_stat   o_stat,
    rbb_out_if.source o_res
);

    t_result            r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wp;
    logic [Q_PTR_W-1:0] r_rp;
    logic [Q_CNT_W-1:0] r_count;

    logic               pop;
    logic [Q_CNT_W-1:0] n_count;

    assign pop = o_res.valid && o_res.ready;

    always_comb begin
        n_count = r_count;
        if (i_push.push) begin
            n_count = n_count + Q_CNT_W'(i_push.n);
        end
        if (pop) begin
            n_count = n_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (i_push.push) begin
                r_wp <= r_wp + Q_PTR_W'(i_push.n);
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < N_SLOTS; i++) begin
            if (i_push.push && (N_W'(i) < i_push.n)) begin
                r_mem[r_wp + Q_PTR_W'(i)] <= i_push.ent[i];
            end
        end
    end

    assign o_stat.count    = r_count;
    assign o_res.valid     = (r_count != '0);
    assign o_res.out_pixel = r_mem[r_rp].pixel;
    assign o_res.out_col   = r_mem[r_rp].col;
    assign o_res.out_row   = r_mem[r_rp].row;
    assign o_res.last      = r_mem[r_rp].last;

endmodule
